// ===== src/mfs_pkg.sv =====
package mfs_pkg;

    localparam int LEVELS  = 4;
    localparam int THREADS = 16;

    localparam int TID_W  = $clog2(THREADS);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int CNT_W  = $clog2(THREADS + 1);
    localparam int SWL_W  = $clog2(LEVELS + 1);
    localparam int TICK_W = 32;
    localparam int THR_W  = LVL_W + TICK_W;

    // command codes
    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_CREATE = 3'd1,
        CMD_WAKE   = 3'd2,
        CMD_YIELD  = 3'd3,
        CMD_EXIT   = 3'd4,
        CMD_BLOCK  = 3'd5
    } t_cmd;

    // register indexes
    localparam logic [1:0] REG_SLICE_STEP    = 2'd0;
    localparam logic [1:0] REG_AGE_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_CHECK_PERIOD  = 2'd2;

    typedef struct packed {
        logic             en;
        logic [LVL_W-1:0] lv;
        logic [TID_W-1:0] t;
    } t_push;

    typedef struct packed {
        logic             en;
        logic [LVL_W-1:0] lv;
        logic [TID_W-1:0] nxt;
    } t_pop;

    typedef struct packed {
        logic             en;
        logic [LVL_W-1:0] lv;
        logic [TID_W-1:0] cur;
        logic [TID_W-1:0] prev;
        logic             has_prev;
        logic [TID_W-1:0] nxt;
    } t_unlink;

    typedef struct packed {
        logic             en;
        logic [TID_W-1:0] addr;
        logic [TID_W-1:0] data;
    } t_lwr;

endpackage

// ===== src/mfs_ram.sv =====
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/mfs_queues.sv =====
module mfs_queues (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  mfs_pkg::t_push                            i_push,
    input  mfs_pkg::t_pop                             i_pop,
    input  mfs_pkg::t_unlink                          i_unl,
    output logic [mfs_pkg::LEVELS-1:0][mfs_pkg::TID_W-1:0] o_head,
    output logic [mfs_pkg::LEVELS-1:0][mfs_pkg::CNT_W-1:0] o_len,
    output mfs_pkg::t_lwr                             o_push_lnk,
    output logic                                      o_pick_valid,
    output logic [mfs_pkg::LVL_W-1:0]                 o_pick_lv,
    output logic [mfs_pkg::CNT_W-1:0]                 o_total
);

    logic [mfs_pkg::LEVELS-1:0][mfs_pkg::TID_W-1:0] r_head;
    logic [mfs_pkg::LEVELS-1:0][mfs_pkg::TID_W-1:0] r_tail;
    logic [mfs_pkg::LEVELS-1:0][mfs_pkg::CNT_W-1:0] r_len;

    assign o_head = r_head;
    assign o_len  = r_len;

    // link update of the old tail when appending to a non-empty queue
    always_comb begin
        o_push_lnk.en   = i_push.en && (r_len[i_push.lv] != '0);
        o_push_lnk.addr = r_tail[i_push.lv];
        o_push_lnk.data = i_push.t;
    end

    // lowest-numbered (highest-priority) non-empty level and total waiting
    always_comb begin
        o_pick_valid = 1'b0;
        o_pick_lv    = '0;
        o_total      = '0;
        for (int i = mfs_pkg::LEVELS - 1; i >= 0; i--) begin
            if (r_len[i] != '0) begin
                o_pick_valid = 1'b1;
                o_pick_lv    = mfs_pkg::LVL_W'(i);
            end
            o_total = o_total + r_len[i];
        end
    end

    // head, tail and length updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_len  <= '0;
        end else begin
            if (i_push.en) begin
                if (r_len[i_push.lv] == '0) begin
                    r_head[i_push.lv] <= i_push.t;
                end
                r_tail[i_push.lv] <= i_push.t;
                r_len[i_push.lv]  <= r_len[i_push.lv] + 1'b1;
            end
            if (i_pop.en) begin
                r_head[i_pop.lv] <= i_pop.nxt;
                r_len[i_pop.lv]  <= r_len[i_pop.lv] - 1'b1;
            end
            if (i_unl.en) begin
                if (!i_unl.has_prev) begin
                    r_head[i_unl.lv] <= i_unl.nxt;
                end
                if (i_unl.cur == r_tail[i_unl.lv]) begin
                    r_tail[i_unl.lv] <= i_unl.prev;
                end
                r_len[i_unl.lv] <= r_len[i_unl.lv] - 1'b1;
            end
        end
    end

endmodule

// ===== src/multilevel_feedback_scheduler.sv =====
// Multilevel feedback queue scheduler with aging. Each input word carries one event
// (tick, create, wake, yield, exit, block) and gives exactly one output word with the
// running thread, its valid flag and the number of threads waiting. Thread links and
// per-thread level and last-run tick sit in two single-port-write RAMs with registered
// read; queue heads, tails and lengths are flip-flops. The sequencer does one RAM access
// per step. A create or wake passes through S_ENQ_RD and S_ENQ; an ignored event or an
// unused code goes straight to S_DONE. A scheduling call steps through S_RUN, then
// S_RUN_EVAL when a thread runs, then S_PICK when nothing runs or the running thread
// leaves, and S_PICK_UPD when another is picked. A call that runs the aging sweep first
// walks every queue below level 0 and moves each aged thread to level 0. S_IDLE follows
// S_DONE before the next word is taken.
// A new event is taken while the previous output word still waits; the sequencer stalls
// in its last step only if a second output word would meet the first still waiting.
module multilevel_feedback_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // command[2:0], thread[6:3], level[8:7], zero fill
    input  logic [15:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // running_thread[3:0], running_valid[4], ready_count[9:5], zero fill
    output logic [15:0] o_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int TW = mfs_pkg::TID_W;
    localparam int LW = mfs_pkg::LVL_W;
    localparam int KW = mfs_pkg::TICK_W;

    typedef enum logic [11:0] {
        S_IDLE     = 12'h001,
        S_ENQ_RD   = 12'h002,
        S_ENQ      = 12'h004,
        S_SW_LVL   = 12'h008,
        S_SW_CHK   = 12'h010,
        S_SW_EVAL  = 12'h020,
        S_SW_PUSH  = 12'h040,
        S_RUN      = 12'h080,
        S_RUN_EVAL = 12'h100,
        S_PICK     = 12'h200,
        S_PICK_UPD = 12'h400,
        S_DONE     = 12'h800
    } t_state;

    t_state r_state;

    // configuration
    logic [7:0]  r_step;
    logic [15:0] r_age;
    logic [7:0]  r_period;

    // scheduler state
    logic [KW-1:0]            r_tick;
    logic [15:0]              r_slice;
    logic [TW-1:0]            r_cur;
    logic                     r_cur_valid;
    logic [7:0]               r_sweep;
    logic [mfs_pkg::THREADS-1:0] r_queued;

    // latched event
    mfs_pkg::t_cmd            r_cmd;
    logic [TW-1:0]            r_tid;
    logic [LW-1:0]            r_lvl;

    // sweep walker
    logic [mfs_pkg::SWL_W-1:0] r_sw_lv;
    logic [TW-1:0]             r_sw_cur;
    logic [TW-1:0]             r_sw_prev;
    logic                      r_sw_has_prev;
    logic [TW-1:0]             r_sw_nxt;
    logic [mfs_pkg::CNT_W-1:0] r_sw_n;

    logic [TW-1:0] r_pk_t;
    logic [LW-1:0] r_pk_lv;

    logic [15:0] r_odata;
    logic        r_ovalid;

    // queue control
    mfs_pkg::t_push   push;
    mfs_pkg::t_pop    pop;
    mfs_pkg::t_unlink unl;
    mfs_pkg::t_lwr    push_lnk;
    logic [mfs_pkg::LEVELS-1:0][TW-1:0]             head;
    logic [mfs_pkg::LEVELS-1:0][mfs_pkg::CNT_W-1:0] len;
    logic                      pick_valid;
    logic [LW-1:0]             pick_lv;
    logic [mfs_pkg::CNT_W-1:0] total;

    // ram ports
    logic                      lnk_we;
    logic [TW-1:0]             lnk_waddr;
    logic [TW-1:0]             lnk_wdata;
    logic [TW-1:0]             lnk_rd;
    logic                      thr_we;
    logic [TW-1:0]             thr_waddr;
    logic [mfs_pkg::THR_W-1:0] thr_wdata;
    logic [mfs_pkg::THR_W-1:0] thr_rd;
    logic [TW-1:0]             raddr;

    // input word fields
    logic [2:0]    in_cmd;
    logic [3:0]    in_tid;
    logic [1:0]    in_lvl;
    logic          s_acc;
    logic          tid_ok;
    logic          busy;
    logic [TW-1:0] tid_i;

    // run evaluation
    logic [LW-1:0]   rd_lv;
    logic [KW-1:0]   rd_last;
    logic [15:0]     slice_n;
    logic [LW+8:0]   limit;
    logic [LW-1:0]   demote_lv;
    logic            expired;
    logic            aged;
    logic [KW-1:0]   idle_ticks;
    logic            cfg_wr;

    assign in_cmd = i_s_tdata[2:0];
    assign in_tid = i_s_tdata[6:3];
    assign in_lvl = i_s_tdata[8:7];
    assign tid_i  = TW'(in_tid);
    assign tid_ok = int'(in_tid) < mfs_pkg::THREADS;
    assign busy   = r_queued[tid_i] || (r_cur_valid && (r_cur == tid_i));

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    assign rd_lv      = thr_rd[mfs_pkg::THR_W-1:KW];
    assign rd_last    = thr_rd[KW-1:0];
    assign slice_n    = (r_slice == 16'hFFFF) ? r_slice : r_slice + 16'd1;
    assign limit      = ((LW+9)'({1'b0, rd_lv}) + (LW+9)'(1)) * (LW+9)'(r_step);
    assign expired    = 32'(slice_n) >= 32'(limit);
    assign demote_lv  = (rd_lv == LW'(mfs_pkg::LEVELS - 1)) ? rd_lv : rd_lv + 1'b1;
    assign idle_ticks = r_tick - rd_last;
    assign aged       = idle_ticks >= KW'(r_age);

    // apb register port
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    always_comb begin
        case (i_paddr[3:2])
            mfs_pkg::REG_SLICE_STEP:    o_prdata = 32'(r_step);
            mfs_pkg::REG_AGE_THRESHOLD: o_prdata = 32'(r_age);
            mfs_pkg::REG_CHECK_PERIOD:  o_prdata = 32'(r_period);
            default:                    o_prdata = '0;
        endcase
    end

    // queue operations per step
    always_comb begin
        push = '0;
        pop  = '0;
        unl  = '0;
        case (r_state)
            S_ENQ: begin
                push.en = 1'b1;
                push.t  = r_tid;
                push.lv = (r_cmd == mfs_pkg::CMD_CREATE) ? '0 : r_lvl;
            end
            S_SW_EVAL: begin
                unl.en       = aged;
                unl.lv       = LW'(r_sw_lv);
                unl.cur      = r_sw_cur;
                unl.prev     = r_sw_prev;
                unl.has_prev = r_sw_has_prev;
                unl.nxt      = lnk_rd;
            end
            S_SW_PUSH: begin
                push.en = 1'b1;
                push.t  = r_sw_cur;
                push.lv = '0;
            end
            S_RUN_EVAL: begin
                push.t = r_cur;
                if (r_cmd == mfs_pkg::CMD_YIELD) begin
                    push.en = 1'b1;
                    push.lv = rd_lv;
                end else if (r_cmd == mfs_pkg::CMD_TICK && expired) begin
                    push.en = 1'b1;
                    push.lv = demote_lv;
                end
            end
            S_PICK_UPD: begin
                pop.en  = 1'b1;
                pop.lv  = r_pk_lv;
                pop.nxt = lnk_rd;
            end
            default: begin
            end
        endcase
    end

    // ram access selection
    always_comb begin
        lnk_we    = push_lnk.en;
        lnk_waddr = push_lnk.addr;
        lnk_wdata = push_lnk.data;
        if (r_state == S_SW_EVAL) begin
            lnk_we    = aged && r_sw_has_prev;
            lnk_waddr = r_sw_prev;
            lnk_wdata = lnk_rd;
        end
        thr_we    = 1'b0;
        thr_waddr = r_cur;
        thr_wdata = {rd_lv, r_tick};
        case (r_state)
            S_ENQ: begin
                thr_we    = 1'b1;
                thr_waddr = r_tid;
                thr_wdata = (r_cmd == mfs_pkg::CMD_CREATE) ? {LW'(0), r_tick} :
                                                             {r_lvl, rd_last};
            end
            S_SW_EVAL: begin
                thr_we    = aged;
                thr_waddr = r_sw_cur;
                thr_wdata = {LW'(0), rd_last};
            end
            S_RUN_EVAL: begin
                if (r_cmd == mfs_pkg::CMD_TICK) begin
                    thr_we    = 1'b1;
                    thr_wdata = expired ? {demote_lv, rd_last} : {rd_lv, r_tick};
                end
            end
            S_PICK_UPD: begin
                thr_we    = 1'b1;
                thr_waddr = r_pk_t;
            end
            default: begin
            end
        endcase
        case (r_state)
            S_SW_CHK: raddr = r_sw_cur;
            S_RUN:    raddr = r_cur;
            S_PICK:   raddr = head[pick_lv];
            default:  raddr = r_tid;
        endcase
    end

    mfs_queues u_queues (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .i_unl        (unl),
        .o_head       (head),
        .o_len        (len),
        .o_push_lnk   (push_lnk),
        .o_pick_valid (pick_valid),
        .o_pick_lv    (pick_lv),
        .o_total      (total)
    );

    mfs_ram #(.WIDTH(TW), .DEPTH(mfs_pkg::THREADS)) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_raddr (raddr),
        .o_rdata (lnk_rd)
    );

    mfs_ram #(.WIDTH(mfs_pkg::THR_W), .DEPTH(mfs_pkg::THREADS)) u_thr_ram (
        .i_clk   (i_clk),
        .i_we    (thr_we),
        .i_waddr (thr_waddr),
        .i_wdata (thr_wdata),
        .i_raddr (raddr),
        .o_rdata (thr_rd)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= 8'd1;
            r_age    <= 16'd20;
            r_period <= 8'd4;
        end else if (cfg_wr) begin
            if (i_paddr[3:2] == mfs_pkg::REG_SLICE_STEP) begin
                r_step <= i_pwdata[7:0];
            end
            if (i_paddr[3:2] == mfs_pkg::REG_AGE_THRESHOLD) begin
                r_age <= i_pwdata[15:0];
            end
            if (i_paddr[3:2] == mfs_pkg::REG_CHECK_PERIOD) begin
                r_period <= i_pwdata[7:0];
            end
        end
    end

    // event payload latches
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd <= mfs_pkg::t_cmd'(in_cmd);
            r_tid <= tid_i;
            r_lvl <= LW'(in_lvl);
        end
        if (r_state == S_PICK) begin
            r_pk_t  <= head[pick_lv];
            r_pk_lv <= pick_lv;
        end
        if (r_state == S_DONE && (!r_ovalid || i_m_tready)) begin
            r_odata <= {6'd0, 5'(total), r_cur_valid, r_cur_valid ? 4'(r_cur) : 4'd0};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tick        <= '0;
            r_slice       <= '0;
            r_cur         <= '0;
            r_cur_valid   <= 1'b0;
            r_sweep       <= '0;
            r_queued      <= '0;
            r_ovalid      <= 1'b0;
            r_sw_lv       <= '0;
            r_sw_cur      <= '0;
            r_sw_prev     <= '0;
            r_sw_has_prev <= 1'b0;
            r_sw_nxt      <= '0;
            r_sw_n        <= '0;
        end else begin
            // output word valid flag
            if (r_state == S_DONE && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (push.en) begin
                r_queued[push.t] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        case (in_cmd)
                            mfs_pkg::CMD_CREATE: begin
                                r_state <= (tid_ok && !busy) ? S_ENQ_RD : S_DONE;
                            end
                            mfs_pkg::CMD_WAKE: begin
                                r_state <= (tid_ok && !busy &&
                                            int'(in_lvl) < mfs_pkg::LEVELS) ?
                                           S_ENQ_RD : S_DONE;
                            end
                            mfs_pkg::CMD_TICK, mfs_pkg::CMD_YIELD,
                            mfs_pkg::CMD_EXIT, mfs_pkg::CMD_BLOCK: begin
                                r_tick <= r_tick + 1'b1;
                                if (r_sweep >= r_period) begin
                                    r_sweep <= '0;
                                    r_sw_lv <= mfs_pkg::SWL_W'(1);
                                    r_state <= S_SW_LVL;
                                end else begin
                                    r_sweep <= r_sweep + 1'b1;
                                    r_state <= S_RUN;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_ENQ_RD: r_state <= S_ENQ;
                S_ENQ:    r_state <= S_DONE;
                S_SW_LVL: begin
                    if (r_sw_lv == mfs_pkg::SWL_W'(mfs_pkg::LEVELS)) begin
                        r_state <= S_RUN;
                    end else begin
                        r_sw_cur      <= head[LW'(r_sw_lv)];
                        r_sw_n        <= len[LW'(r_sw_lv)];
                        r_sw_prev     <= '0;
                        r_sw_has_prev <= 1'b0;
                        r_state       <= S_SW_CHK;
                    end
                end
                S_SW_CHK: begin
                    if (r_sw_n == '0) begin
                        r_sw_lv <= r_sw_lv + 1'b1;
                        r_state <= S_SW_LVL;
                    end else begin
                        r_state <= S_SW_EVAL;
                    end
                end
                S_SW_EVAL: begin
                    if (aged) begin
                        r_sw_nxt <= lnk_rd;
                        r_state  <= S_SW_PUSH;
                    end else begin
                        r_sw_prev     <= r_sw_cur;
                        r_sw_has_prev <= 1'b1;
                        r_sw_cur      <= lnk_rd;
                        r_sw_n        <= r_sw_n - 1'b1;
                        r_state       <= S_SW_CHK;
                    end
                end
                S_SW_PUSH: begin
                    r_sw_cur <= r_sw_nxt;
                    r_sw_n   <= r_sw_n - 1'b1;
                    r_state  <= S_SW_CHK;
                end
                S_RUN: r_state <= r_cur_valid ? S_RUN_EVAL : S_PICK;
                S_RUN_EVAL: begin
                    r_slice <= slice_n;
                    if (r_cmd == mfs_pkg::CMD_TICK && !expired) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_slice <= '0;
                    if (pick_valid) begin
                        r_state <= S_PICK_UPD;
                    end else begin
                        r_cur_valid <= 1'b0;
                        r_state     <= S_DONE;
                    end
                end
                S_PICK_UPD: begin
                    r_queued[r_pk_t] <= 1'b0;
                    r_cur            <= r_pk_t;
                    r_cur_valid      <= 1'b1;
                    r_state          <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // between events the running thread is never also waiting in a queue
    a_cur_not_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_cur_valid) |-> !r_queued[r_cur])
        else $error("running thread marked as queued");

    // a pick with a non-empty queue always leaves a thread running
    a_pick_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK_UPD) |=> r_cur_valid)
        else $error("pick left nothing running");

    // queue lengths agree with the queued flags between events
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(total) == $countones(r_queued)))
        else $error("queue lengths disagree with queued flags");

endmodule

// ===== sim/tb_multilevel_feedback_scheduler.sv =====
`timescale 1ns / 1ps

module tb_multilevel_feedback_scheduler;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [3:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    // one expected output word
    typedef struct packed {
        logic [3:0] thread;
        logic       valid;
        logic [4:0] ready;
    } t_sched_word;

    // scheduler state mirror and queue of expected words
    class sched_scoreboard;
        logic [3:0]  head[mfs_pkg::LEVELS];
        logic [3:0]  tail[mfs_pkg::LEVELS];
        int          qlen[mfs_pkg::LEVELS];
        logic [3:0]  link[mfs_pkg::THREADS];
        logic [1:0]  prio[mfs_pkg::THREADS];
        logic [31:0] last_run[mfs_pkg::THREADS];
        bit          waiting[mfs_pkg::THREADS];
        logic [31:0] ticks;
        int          slice;
        logic [3:0]  cur;
        bit          cur_ok;
        int          sweep_cnt;
        int          step;
        int          age_limit;
        int          period;
        t_sched_word pending[$];
        int          errors;

        function new();
            for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
                head[l] = 0; tail[l] = 0; qlen[l] = 0;
            end
            for (int t = 0; t < mfs_pkg::THREADS; t++) begin
                link[t] = 0; prio[t] = 0; last_run[t] = 0; waiting[t] = 0;
            end
            ticks = 0; slice = 0; cur = 0; cur_ok = 0; sweep_cnt = 0;
            step = 1; age_limit = 20; period = 4; errors = 0;
        endfunction

        function void set_reg(int idx, int val);
            if (idx == mfs_pkg::REG_SLICE_STEP) step = val & 8'hff;
            else if (idx == mfs_pkg::REG_AGE_THRESHOLD) age_limit = val & 16'hffff;
            else if (idx == mfs_pkg::REG_CHECK_PERIOD) period = val & 8'hff;
        endfunction

        function void enqueue(logic [3:0] t, int l);
            if (qlen[l] == 0) head[l] = t;
            else link[tail[l]] = t;
            tail[l] = t;
            qlen[l]++;
            prio[t] = l;
            waiting[t] = 1;
        endfunction

        function void promote_idle();
            logic [3:0] c, p, n;
            bit has_p;
            int cnt;
            for (int l = 1; l < mfs_pkg::LEVELS; l++) begin
                c = head[l]; p = 0; has_p = 0; cnt = qlen[l];
                for (int k = 0; k < cnt; k++) begin
                    n = link[c];
                    if (ticks - last_run[c] >= 32'(age_limit)) begin
                        if (has_p) link[p] = n;
                        else head[l] = n;
                        if (c == tail[l]) tail[l] = p;
                        qlen[l]--;
                        enqueue(c, 0);
                    end else begin
                        p = c; has_p = 1;
                    end
                    c = n;
                end
            end
        endfunction

        function void dispatch();
            cur_ok = 0;
            slice = 0;
            for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
                if (qlen[l] != 0) begin
                    cur = head[l];
                    head[l] = link[cur];
                    qlen[l]--;
                    waiting[cur] = 0;
                    cur_ok = 1;
                    return;
                end
            end
        endfunction

        function void sched_call(logic [2:0] cmd);
            logic [1:0] l;
            int quota;
            ticks++;
            if (sweep_cnt >= period) begin
                sweep_cnt = 0;
                promote_idle();
            end else begin
                sweep_cnt++;
            end
            if (cur_ok) begin
                l = prio[cur];
                quota = (int'(l) + 1) * step;
                if (slice < 16'hffff) slice++;
                if (cmd == mfs_pkg::CMD_YIELD) begin
                    enqueue(cur, l);
                    dispatch();
                end else if (cmd == mfs_pkg::CMD_EXIT || cmd == mfs_pkg::CMD_BLOCK) begin
                    dispatch();
                end else if (slice >= quota) begin
                    enqueue(cur, (l == mfs_pkg::LEVELS - 1) ? l : l + 1);
                    dispatch();
                end
            end else begin
                dispatch();
            end
            if (cur_ok) last_run[cur] = ticks;
        endfunction

        // note one accepted input word
        function void note_input(logic [15:0] d);
            logic [2:0] cmd;
            logic [3:0] tid;
            logic [1:0] lvl;
            t_sched_word w;
            int total;
            cmd = d[2:0]; tid = d[6:3]; lvl = d[8:7];
            if (cmd == mfs_pkg::CMD_CREATE || cmd == mfs_pkg::CMD_WAKE) begin
                if (!(waiting[tid] || (cur_ok && cur == tid))) begin
                    if (cmd == mfs_pkg::CMD_CREATE) begin
                        last_run[tid] = ticks;
                        enqueue(tid, 0);
                    end else begin
                        enqueue(tid, lvl);
                    end
                end
            end else if (cmd <= mfs_pkg::CMD_BLOCK) begin
                sched_call(cmd);
            end
            total = 0;
            for (int l = 0; l < mfs_pkg::LEVELS; l++) total += qlen[l];
            w.thread = cur_ok ? cur : 4'd0;
            w.valid = cur_ok;
            w.ready = 5'(total);
            pending.push_back(w);
        endfunction

        // check one accepted output word
        function void check_output(logic [15:0] d);
            t_sched_word e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", d);
                return;
            end
            e = pending.pop_front();
            if (d[3:0] !== e.thread || d[4] !== e.valid || d[9:5] !== e.ready) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected thread %0d valid %0d ready %0d, got %0d %0d %0d",
                             e.thread, e.valid, e.ready, d[3:0], d[4], d[9:5]);
            end
        endfunction
    endclass

    sched_scoreboard sb;
    bit created[mfs_pkg::THREADS];
    bit quiet;
    bit hold_sink;
    int idle_cycles;

    multilevel_feedback_scheduler dut (.*);

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    // monitor both sides and run the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_input(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_output(o_m_tdata);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // sink side: random back pressure, plus one long hold-off
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_m_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_sink = 0;
            end
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        i_psel <= 1'b1; i_penable <= 1'b0; i_pwrite <= 1'b1;
        i_paddr <= {idx, 2'b00}; i_pwdata <= val;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_psel <= 1'b0; i_penable <= 1'b0; i_pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    // valid stays high after a word until the next word or an idle burst replaces it
    task automatic send_word(input logic [2:0] cmd, input logic [3:0] tid,
                             input logic [1:0] lvl);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'd0, lvl, tid, cmd};
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd == mfs_pkg::CMD_CREATE) created[tid] = 1;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // random event mix; wake only names slots already created
    task automatic random_events(input int n);
        logic [3:0] t;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            t = 4'($urandom);
            if (r < 18) send_word(mfs_pkg::CMD_CREATE, t, 2'($urandom));
            else if (r < 33 && created[t]) send_word(mfs_pkg::CMD_WAKE, t, 2'($urandom));
            else if (r < 33) send_word(mfs_pkg::CMD_CREATE, t, 2'($urandom));
            else if (r < 65) send_word(mfs_pkg::CMD_TICK, t, 2'($urandom));
            else if (r < 77) send_word(mfs_pkg::CMD_YIELD, t, 2'($urandom));
            else if (r < 85) send_word(mfs_pkg::CMD_EXIT, t, 2'($urandom));
            else if (r < 95) send_word(mfs_pkg::CMD_BLOCK, t, 2'($urandom));
            else send_word(3'($urandom_range(6, 7)), t, 2'($urandom));
        end
    endtask

    initial begin
        sb = new();
        quiet = 0; hold_sink = 0; idle_cycles = 0;
        for (int t = 0; t < mfs_pkg::THREADS; t++) created[t] = 0;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0;
        i_psel = 1'b0; i_penable = 1'b0; i_pwrite = 1'b0; i_paddr = '0; i_pwdata = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty calls, extremes of slots and levels, duplicates, unused codes
        send_word(mfs_pkg::CMD_TICK, 4'd0, 2'd0);
        send_word(mfs_pkg::CMD_YIELD, 4'd0, 2'd0);
        send_word(mfs_pkg::CMD_CREATE, 4'd15, 2'd3);
        send_word(mfs_pkg::CMD_CREATE, 4'd0, 2'd0);
        send_word(mfs_pkg::CMD_CREATE, 4'd15, 2'd0);
        send_word(mfs_pkg::CMD_TICK, 4'd0, 2'd0);
        send_word(mfs_pkg::CMD_CREATE, 4'd15, 2'd0);
        send_word(mfs_pkg::CMD_WAKE, 4'd0, 2'd3);
        send_word(3'd6, 4'd5, 2'd1);
        send_word(3'd7, 4'd10, 2'd2);
        send_word(mfs_pkg::CMD_CREATE, 4'd10, 2'd0);
        send_word(mfs_pkg::CMD_CREATE, 4'd5, 2'd0);
        for (int i = 0; i < 6; i++) send_word(mfs_pkg::CMD_TICK, 4'd0, 2'd0);
        send_word(mfs_pkg::CMD_YIELD, 4'd0, 2'd0);
        send_word(mfs_pkg::CMD_BLOCK, 4'd0, 2'd0);
        send_word(mfs_pkg::CMD_WAKE, 4'd15, 2'd3);
        send_word(mfs_pkg::CMD_EXIT, 4'd0, 2'd0);
        send_word(mfs_pkg::CMD_WAKE, 4'd10, 2'd2);
        send_word(mfs_pkg::CMD_EXIT, 4'd0, 2'd0);
        drain();

        // phases over register settings, extremes included
        apb_write(mfs_pkg::REG_SLICE_STEP, 255);
        apb_write(mfs_pkg::REG_AGE_THRESHOLD, 65535);
        apb_write(mfs_pkg::REG_CHECK_PERIOD, 0);
        random_events(250);
        hold_sink = 1;
        random_events(60);
        drain();
        apb_write(mfs_pkg::REG_SLICE_STEP, 2);
        apb_write(mfs_pkg::REG_AGE_THRESHOLD, 1);
        apb_write(mfs_pkg::REG_CHECK_PERIOD, 255);
        random_events(350);
        drain();
        apb_write(mfs_pkg::REG_SLICE_STEP, 1);
        apb_write(mfs_pkg::REG_AGE_THRESHOLD, 8);
        apb_write(mfs_pkg::REG_CHECK_PERIOD, 1);
        random_events(400);
        drain();
        apb_write(mfs_pkg::REG_SLICE_STEP, 3);
        apb_write(mfs_pkg::REG_AGE_THRESHOLD, 30);
        apb_write(mfs_pkg::REG_CHECK_PERIOD, 3);
        random_events(400);
        quiet = 1;
        random_events(270);
        drain();

        if (sb.errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
